// File: rtl/chip8_instruction_step_defines.svh
// assertion macros shared by the chip8 step rtl
// no dependencies
`ifndef CHIP8_INSTRUCTION_STEP_DEFINES_SVH
`define CHIP8_INSTRUCTION_STEP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define C8_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define C8_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: rtl/c8_pkg.sv
// package for the chip8 step block: types, constants, helpers
// no dependencies
`default_nettype none
package c8_pkg;
	localparam int MemBytes   = 4096;
	localparam int StackDepth = 16;
	localparam int SpW        = $clog2(StackDepth + 1);
	localparam int StkAw      = $clog2(StackDepth);
	localparam int Pixels     = 2048;
	localparam logic [11:0] PcReset = 12'h200;

	typedef enum logic [1:0] {
		OP_EXEC  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OVER  = 2'd1,
		ST_UNDER = 2'd2,
		ST_UNK   = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE, S_RD_WAIT, S_FETCH_HI, S_FETCH_LO, S_DECODE, S_EXEC,
		S_RET_WAIT, S_RET, S_BCD1, S_BCD2, S_STORE, S_LOAD_RD, S_LOAD_WR,
		S_DRAW_RD, S_DRAW_ROW, S_DRAW_PIX, S_CLEAR, S_MEMRD_WAIT,
		S_DONE, S_OUT, S_INIT
	} state_t;

	// frame buffer port request
	typedef struct packed {
		logic        we;
		logic [10:0] addr;
		logic        wdata;
	} fb_req_t;

	// byte memory port request
	typedef struct packed {
		logic        we;
		logic [11:0] addr;
		logic [7:0]  wdata;
	} mem_req_t;

	// hundreds digit of a byte and the rest below 100, done as small compares
	function automatic logic [3:0] bcd_hund(input logic [7:0] v);
		logic [3:0] r;
		r = (v >= 8'd200) ? 4'd2 : ((v >= 8'd100) ? 4'd1 : 4'd0);
		return r;
	endfunction

	function automatic logic [6:0] bcd_rem100(input logic [7:0] v);
		logic [7:0] r;
		r = (v >= 8'd200) ? v - 8'd200 : ((v >= 8'd100) ? v - 8'd100 : v);
		return r[6:0];
	endfunction

	// tens digit by reciprocal multiplication, exact below 100
	function automatic logic [3:0] bcd_tens(input logic [6:0] v);
		logic [15:0] p;
		p = {9'd0, v} * 16'd205;
		return p[14:11];
	endfunction

	function automatic logic [3:0] bcd_ones(input logic [6:0] v);
		logic [6:0] t;
		t = 7'(bcd_tens(v)) * 7'd10;
		return 4'(v - t);
	endfunction
endpackage
`default_nettype wire

// File: rtl/c8_ram.sv
// generic single port synchronous ram, registered read
// no dependencies
`default_nettype none
module c8_ram #(
	parameter int Width = 8,
	parameter int Depth = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output      logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// File: rtl/c8_core.sv
// chip8 sequencer: drives the byte memory, stack and frame buffer rams
// depends on c8_pkg, c8_ram, the assertion header
`default_nettype none
`include "chip8_instruction_step_defines.svh"
module c8_core import c8_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [1:0]  op,
	input  wire logic [11:0] address,
	input  wire logic        read_pixel,
	input  wire logic [7:0]  data,
	input  wire logic [7:0]  random_value,
	output      logic        busy,
	output      logic        done,
	output      logic [11:0] pc,
	output      logic [15:0] opcode,
	output      logic [7:0]  read_data,
	output      logic        collision,
	output      logic        waiting_for_key,
	output      logic        sound_active,
	output      logic [1:0]  status
);
	state_t state_q, state_d;
	mem_req_t mreq;
	fb_req_t  freq;
	logic [7:0]  mrd;
	logic        frd;
	logic [11:0] srd;
	logic        swe;
	logic [StkAw-1:0] saddr;
	logic [11:0] swdata;

	c8_ram #(.Width(8), .Depth(MemBytes)) u_mem (
		.clk(clk), .we(mreq.we), .addr(mreq.addr), .wdata(mreq.wdata), .rdata(mrd));
	c8_ram #(.Width(1), .Depth(Pixels)) u_fb (
		.clk(clk), .we(freq.we), .addr(freq.addr), .wdata(freq.wdata), .rdata(frd));
	c8_ram #(.Width(12), .Depth(StackDepth)) u_stk (
		.clk(clk), .we(swe), .addr(saddr), .wdata(swdata), .rdata(srd));

	logic [7:0]  v_q [16];
	logic [11:0] i_q, pc_q;
	logic [SpW-1:0] sp_q;
	logic [7:0]  dt_q, st_q;
	logic [15:0] ins_q;
	logic [7:0]  rd_q;
	logic        hit_q, wait_q;
	logic [1:0]  stat_q;
	logic [11:0] addr_q;
	logic        pix_q;
	logic [7:0]  rnd_q;
	logic [3:0]  cnt_q;
	logic [2:0]  col_q;
	logic [7:0]  bits_q;
	logic [10:0] ccnt_q;
	logic [6:0]  rem_q;

	// next-value wires
	logic [7:0]  v_d [16];
	logic [11:0] i_d, pc_d;
	logic [SpW-1:0] sp_d;
	logic [7:0]  dt_d, st_d;
	logic [15:0] ins_d;
	logic [7:0]  rd_d;
	logic        hit_d, wait_d;
	logic [1:0]  stat_d;
	logic [3:0]  cnt_d;
	logic [2:0]  col_d;
	logic [7:0]  bits_d;
	logic [10:0] ccnt_d;
	logic [6:0]  rem_d;

	logic [3:0] x, y, n;
	logic [7:0] kk, vx, vy;
	logic [8:0] sum;
	logic [5:0] px;
	logic [4:0] py;
	logic [10:0] paddr;

	assign x  = ins_q[11:8];
	assign y  = ins_q[7:4];
	assign n  = ins_q[3:0];
	assign kk = ins_q[7:0];
	assign vx = v_q[x];
	assign vy = v_q[y];
	assign sum = {1'b0, vx} + {1'b0, vy};
	assign px = 6'(vx[5:0] + {3'b0, col_q});
	assign py = 5'(vy[4:0] + {1'b0, cnt_q});
	assign paddr = {py, px};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			for (int k = 0; k < 16; k++) v_q[k] <= '0;
			i_q <= '0; pc_q <= PcReset; sp_q <= '0; dt_q <= '0; st_q <= '0;
			ccnt_q <= '0;
		end else begin
			state_q <= state_d;
			for (int k = 0; k < 16; k++) v_q[k] <= v_d[k];
			i_q <= i_d; pc_q <= pc_d; sp_q <= sp_d; dt_q <= dt_d; st_q <= st_d;
			ccnt_q <= ccnt_d;
		end
	end

	always_ff @(posedge clk) begin
		ins_q <= ins_d; rd_q <= rd_d; hit_q <= hit_d; wait_q <= wait_d;
		stat_q <= stat_d; cnt_q <= cnt_d; col_q <= col_d; bits_q <= bits_d;
		rem_q <= rem_d;
		if (start) begin
			addr_q <= address; pix_q <= read_pixel;
			rnd_q <= random_value;
		end
	end

	always_comb begin
		state_d = state_q;
		for (int k = 0; k < 16; k++) v_d[k] = v_q[k];
		i_d = i_q; pc_d = pc_q; sp_d = sp_q; dt_d = dt_q; st_d = st_q;
		ins_d = ins_q; rd_d = rd_q; hit_d = hit_q; wait_d = wait_q; stat_d = stat_q;
		cnt_d = cnt_q; col_d = col_q; bits_d = bits_q; ccnt_d = ccnt_q; rem_d = rem_q;
		mreq = '{we: 1'b0, addr: pc_q, wdata: 8'd0};
		freq = '{we: 1'b0, addr: paddr, wdata: 1'b0};
		swe = 1'b0;
		saddr = StkAw'(sp_q);
		swdata = pc_q;
		done = 1'b0;
		case (state_q)
			S_INIT: begin
				// darken the frame buffer after reset, one pixel per cycle
				freq = '{we: 1'b1, addr: ccnt_q, wdata: 1'b0};
				ccnt_d = ccnt_q + 11'd1;
				if (ccnt_q == 11'(Pixels - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					ins_d = '0; rd_d = '0; hit_d = 1'b0; wait_d = 1'b0; stat_d = ST_OK;
					case (op_t'(op))
						OP_EXEC: begin
							mreq.addr = pc_q;
							state_d = S_FETCH_HI;
						end
						OP_WRITE: begin
							mreq = '{we: 1'b1, addr: address, wdata: data};
							state_d = S_DONE;
						end
						OP_READ: begin
							mreq.addr = address;
							freq.addr = address[10:0];
							state_d = S_MEMRD_WAIT;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_MEMRD_WAIT: begin
				if (pix_q) rd_d = (addr_q[11] == 1'b0) ? {7'd0, frd} : 8'd0;
				else rd_d = mrd;
				state_d = S_DONE;
			end
			S_FETCH_HI: begin
				ins_d[15:8] = mrd;
				mreq.addr = pc_q + 12'd1;
				state_d = S_FETCH_LO;
			end
			S_FETCH_LO: begin
				ins_d[7:0] = mrd;
				pc_d = pc_q + 12'd2;
				state_d = S_DECODE;
			end
			S_DECODE: begin
				state_d = S_EXEC;
				case (ins_q[15:12])
					4'h0: begin
						if (ins_q == 16'h00E0) begin
							ccnt_d = '0;
							state_d = S_CLEAR;
						end else if (ins_q == 16'h00EE) begin
							if (sp_q == '0) stat_d = ST_UNDER;
							else begin
								saddr = StkAw'(sp_q - 1'b1);
								sp_d = sp_q - 1'b1;
								state_d = S_RET;
							end
						end else stat_d = ST_UNK;
					end
					4'h1: pc_d = ins_q[11:0];
					4'h2: begin
						if (sp_q >= SpW'(StackDepth)) stat_d = ST_OVER;
						else begin
							swe = 1'b1;
							sp_d = sp_q + 1'b1;
							pc_d = ins_q[11:0];
						end
					end
					4'h3: if (vx == kk) pc_d = pc_q + 12'd2;
					4'h4: if (vx != kk) pc_d = pc_q + 12'd2;
					4'h5: begin
						if (n != 4'h0) stat_d = ST_UNK;
						else if (vx == vy) pc_d = pc_q + 12'd2;
					end
					4'h6: v_d[x] = kk;
					4'h7: v_d[x] = vx + kk;
					4'h8: begin
						case (n)
							4'h0: v_d[x] = vy;
							4'h1: v_d[x] = vx | vy;
							4'h2: v_d[x] = vx & vy;
							4'h3: v_d[x] = vx ^ vy;
							4'h4: begin v_d[x] = sum[7:0]; v_d[15] = {7'd0, sum[8]}; end
							4'h5: begin v_d[x] = vx - vy; v_d[15] = {7'd0, vx >= vy}; end
							4'h6: begin v_d[x] = vx >> 1; v_d[15] = {7'd0, vx[0]}; end
							4'h7: begin v_d[x] = vy - vx; v_d[15] = {7'd0, vy >= vx}; end
							4'hE: begin v_d[x] = vx << 1; v_d[15] = {7'd0, vx[7]}; end
							default: stat_d = ST_UNK;
						endcase
					end
					4'h9: begin
						if (n != 4'h0) stat_d = ST_UNK;
						else if (vx != vy) pc_d = pc_q + 12'd2;
					end
					4'hA: i_d = ins_q[11:0];
					4'hB: pc_d = ins_q[11:0] + {4'd0, v_q[0]};
					4'hC: v_d[x] = rnd_q & kk;
					4'hD: begin
						hit_d = 1'b0;
						cnt_d = '0;
						if (n == 4'h0) begin
							v_d[15] = '0;
						end else begin
							mreq.addr = i_q;
							state_d = S_DRAW_RD;
						end
					end
					4'hE: if (kk != 8'h9E && kk != 8'hA1) stat_d = ST_UNK;
					default: begin
						case (kk)
							8'h07: v_d[x] = dt_q;
							8'h0A: wait_d = 1'b1;
							8'h15: dt_d = vx;
							8'h18: st_d = vx;
							8'h1E: i_d = i_q + {4'd0, vx};
							8'h29: i_d = {8'd0, vx[3:0]} * 12'd5;
							8'h33: begin
								mreq = '{we: 1'b1, addr: i_q, wdata: {4'd0, bcd_hund(vx)}};
								rem_d = bcd_rem100(vx);
								state_d = S_BCD1;
							end
							8'h55: begin cnt_d = '0; state_d = S_STORE; end
							8'h65: begin cnt_d = '0; state_d = S_LOAD_RD; end
							default: stat_d = ST_UNK;
						endcase
					end
				endcase
			end
			S_RET: begin
				// stack read data is valid in the cycle after the pop address
				pc_d = srd;
				state_d = S_EXEC;
			end
			S_BCD1: begin
				mreq = '{we: 1'b1, addr: i_q + 12'd1, wdata: {4'd0, bcd_tens(rem_q)}};
				state_d = S_BCD2;
			end
			S_BCD2: begin
				mreq = '{we: 1'b1, addr: i_q + 12'd2, wdata: {4'd0, bcd_ones(rem_q)}};
				state_d = S_EXEC;
			end
			S_STORE: begin
				mreq = '{we: 1'b1, addr: i_q + {8'd0, cnt_q}, wdata: v_q[cnt_q]};
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == x) state_d = S_EXEC;
			end
			S_LOAD_RD: begin
				mreq.addr = i_q + {8'd0, cnt_q};
				state_d = S_LOAD_WR;
			end
			S_LOAD_WR: begin
				v_d[cnt_q] = mrd;
				cnt_d = cnt_q + 4'd1;
				state_d = (cnt_q == x) ? S_EXEC : S_LOAD_RD;
			end
			S_DRAW_RD: begin
				mreq.addr = i_q + {8'd0, cnt_q};
				col_d = '0;
				state_d = S_DRAW_ROW;
			end
			S_DRAW_ROW: begin
				bits_d = mrd;
				col_d = '0;
				state_d = S_DRAW_PIX;
			end
			S_DRAW_PIX: begin
				// a lit sprite bit is handled in two steps: read the pixel, then flip it
				if (bits_q[7]) begin
					freq.addr = paddr;
					bits_d = bits_q;
					state_d = S_RD_WAIT;
				end else begin
					bits_d = bits_q << 1;
					col_d = col_q + 3'd1;
					if (col_q == 3'd7) begin
						cnt_d = cnt_q + 4'd1;
						if (cnt_q + 4'd1 == n) begin
							v_d[15] = {7'd0, hit_q};
							state_d = S_EXEC;
						end else begin
							state_d = S_DRAW_RD;
						end
					end
				end
			end
			S_RD_WAIT: begin
				freq = '{we: 1'b1, addr: paddr, wdata: ~frd};
				if (frd) hit_d = 1'b1;
				bits_d = {bits_q[6:0], 1'b0};
				col_d = col_q + 3'd1;
				state_d = S_DRAW_PIX;
				if (col_q == 3'd7) begin
					cnt_d = cnt_q + 4'd1;
					if (cnt_q + 4'd1 == n) begin
						v_d[15] = {7'd0, hit_q | frd};
						state_d = S_EXEC;
					end else begin
						state_d = S_DRAW_RD;
					end
				end
			end
			S_CLEAR: begin
				freq = '{we: 1'b1, addr: ccnt_q, wdata: 1'b0};
				ccnt_d = ccnt_q + 11'd1;
				if (ccnt_q == 11'(Pixels - 1)) state_d = S_EXEC;
			end
			S_EXEC: begin
				// end of an instruction: timers tick once
				if (dt_q != '0) dt_d = dt_q - 8'd1;
				if (st_q != '0) st_d = st_q - 8'd1;
				state_d = S_DONE;
			end
			S_DONE: begin
				done = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_DECODE && ins_q[15:12] == 4'h2) swdata = pc_q;
	end

	assign busy = (state_q != S_IDLE);
	assign pc = pc_q;
	assign opcode = ins_q;
	assign read_data = rd_q;
	assign collision = hit_q;
	assign waiting_for_key = wait_q;
	assign sound_active = (st_q != '0);
	assign status = stat_q;

	`C8_ASSERT_IMP(a_sp_range, clk, arst_n, 1'b1, sp_q <= SpW'(StackDepth), "stack pointer out of range")
	`C8_ASSERT_NEXT(a_start_leaves_idle, clk, arst_n, start && state_q == S_IDLE, state_q != S_IDLE, "request not taken")
	`C8_ASSERT_IMP(a_no_start_busy, clk, arst_n, start, state_q == S_IDLE, "request while busy")
endmodule
`default_nettype wire

// File: rtl/chip8_instruction_step.sv
// top level of the chip8 step block: stream handshake and result register
// depends on c8_pkg, c8_core
`default_nettype none
// usage:
//   s_axis carries one request: op, address, read_pixel, data, random_value
//   packed into s_axis_tdata from the lowest bit up. m_axis returns exactly one
//   result per request: pc, opcode, read_data, collision, waiting_for_key,
//   sound_active, status, lowest bit first.
// on the way to m_axis_tvalid, a memory write goes from idle to S_DONE, a
//   memory or pixel read passes S_MEMRD_WAIT, and an instruction passes
//   S_FETCH_HI, S_FETCH_LO, S_DECODE and S_EXEC; 00ee adds S_RET, fx33 adds
//   S_BCD1 and S_BCD2, fx55 and fx65 step through v0 to vx on the byte memory
//   port, 00e0 walks every pixel, and a sprite draw walks each row bit by bit
//   and adds a read and a write per set bit on the single frame buffer port
// one request is in flight at a time; the next is taken only once the result
//   has left the output register
// a stalled receiver holds the result in the output register and keeps
//   s_axis_tready low until the result is taken
// reset clears registers, timers, stack pointer, pc (to 0x200) and control,
//   then every pixel of the frame buffer is darkened with s_axis_tready low
// the byte memory is undefined until written.
module chip8_instruction_step import c8_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	// op[1:0], address[13:2], read_pixel[14], data[22:15], random_value[30:23]
	input  wire logic [31:0] s_axis_tdata,
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// pc[11:0], opcode[27:12], read_data[35:28], collision[36],
	// waiting_for_key[37], sound_active[38], status[40:39]
	output      logic [47:0] m_axis_tdata
);
	logic start, busy, done;
	logic [11:0] pc;
	logic [15:0] opcode;
	logic [7:0]  read_data;
	logic        collision, waiting_for_key, sound_active;
	logic [1:0]  status;
	logic        full_q;
	logic [40:0] res_q;

	// take a request only with the core idle and room in the result register
	assign s_axis_tready = !busy && !full_q;
	assign start = s_axis_tvalid && s_axis_tready;

	c8_core u_core (
		.clk(clk), .arst_n(arst_n), .start(start),
		.op(s_axis_tdata[1:0]), .address(s_axis_tdata[13:2]),
		.read_pixel(s_axis_tdata[14]), .data(s_axis_tdata[22:15]),
		.random_value(s_axis_tdata[30:23]),
		.busy(busy), .done(done), .pc(pc), .opcode(opcode), .read_data(read_data),
		.collision(collision), .waiting_for_key(waiting_for_key),
		.sound_active(sound_active), .status(status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (done) begin
			full_q <= 1'b1;
		end else if (m_axis_tready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= {status, sound_active, waiting_for_key, collision, read_data, opcode, pc};
		end
	end

	assign m_axis_tvalid = full_q;
	assign m_axis_tdata = {7'd0, res_q};
endmodule
`default_nettype wire
